// ===== hw/rtl/tcw_pkg.sv =====
// Package for the text console writer: screen geometry, codes and shared types.
// No dependencies; used by tcw_ram, tcw_ctrl and text_console_writer.
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);

    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] NEWLINE_CODE = 8'h0a;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef logic [COL_W-1:0]  col_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef struct packed {
        logic       en;
        addr_t      addr;
        logic [7:0] data;
    } mem_wr_t;

    typedef enum logic [6:0] {
        ST_INIT   = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_READ   = 7'b0000100,
        ST_SCROLL = 7'b0001000,
        ST_FILL   = 7'b0010000,
        ST_DONE   = 7'b0100000,
        ST_SPARE  = 7'b1000000
    } state_t;

endpackage

// ===== hw/rtl/tcw_ram.sv =====
// Screen cell store: one write port and one read port with registered read data.
// Depends on tcw_pkg for geometry and the write request struct.
module tcw_ram
(
    input  logic            clk,
    input  tcw_pkg::mem_wr_t wr,
    input  tcw_pkg::addr_t  rd_addr,
    output logic [7:0]      rd_data
);

    logic [7:0] mem [tcw_pkg::CELLS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
// Sequencer for the text console writer: cursor, operation control, sweeps
// over the cell store and the output register. Depends on tcw_pkg.
module tcw_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       op,
    input  logic [7:0]       char_code,
    input  logic [10:0]      cell_index,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       cell_char,
    output logic [6:0]       cursor_col,
    output logic [4:0]       cursor_row,
    output logic             scrolled,
    output tcw_pkg::mem_wr_t wr,
    output tcw_pkg::addr_t   rd_addr,
    input  logic [7:0]       rd_data
);

    tcw_pkg::state_t state_reg, state_next;
    tcw_pkg::cnt_t   cnt_reg, cnt_next;
    tcw_pkg::col_t   col_reg, col_next;
    tcw_pkg::row_t   row_reg, row_next;
    logic            out_valid_reg, out_valid_next;

    logic [7:0] res_cell_reg, res_cell_next;
    logic       res_scroll_reg, res_scroll_next;
    logic       rd_ok_reg, rd_ok_next;
    logic [7:0] cell_char_reg, cell_char_next;
    logic [6:0] cursor_col_reg, cursor_col_next;
    logic [4:0] cursor_row_reg, cursor_row_next;
    logic       scrolled_reg, scrolled_next;

    logic line_adv;
    logic load_out;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        res_cell_next   = res_cell_reg;
        res_scroll_next = res_scroll_reg;
        rd_ok_next      = rd_ok_reg;
        wr              = '0;
        rd_addr         = '0;
        line_adv        = 1'b0;
        load_out        = 1'b0;

        case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                wr.en   = 1'b1;
                wr.addr = tcw_pkg::addr_t'(cnt_reg);
                wr.data = tcw_pkg::SPACE_CODE;
                if (cnt_reg == tcw_pkg::cnt_t'(tcw_pkg::CELLS - 1))
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + tcw_pkg::cnt_t'(1);
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                rd_addr = tcw_pkg::addr_t'(cell_index);
                if (in_valid)
                begin
                    res_cell_next   = 8'd0;
                    res_scroll_next = 1'b0;
                    state_next      = tcw_pkg::ST_DONE;
                    case (op)
                        tcw_pkg::OP_PUT:
                        begin
                            if (char_code == tcw_pkg::NEWLINE_CODE)
                            begin
                                line_adv = 1'b1;
                            end
                            else
                            begin
                                wr.en   = 1'b1;
                                wr.addr = tcw_pkg::addr_t'(row_reg * tcw_pkg::COLUMNS
                                                           + col_reg);
                                wr.data = char_code;
                                if (col_reg == tcw_pkg::col_t'(tcw_pkg::COLUMNS - 1))
                                begin
                                    line_adv = 1'b1;
                                end
                                else
                                begin
                                    col_next = col_reg + tcw_pkg::col_t'(1);
                                end
                            end
                            if (line_adv)
                            begin
                                col_next = '0;
                                if (row_reg == tcw_pkg::row_t'(tcw_pkg::ROWS - 1))
                                begin
                                    res_scroll_next = 1'b1;
                                    cnt_next        = '0;
                                    state_next      = tcw_pkg::ST_SCROLL;
                                end
                                else
                                begin
                                    row_next = row_reg + tcw_pkg::row_t'(1);
                                end
                            end
                        end
                        tcw_pkg::OP_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = tcw_pkg::ST_FILL;
                        end
                        tcw_pkg::OP_READ:
                        begin
                            rd_ok_next = (cell_index < tcw_pkg::CELLS);
                            state_next = tcw_pkg::ST_READ;
                        end
                        default:
                        begin
                            state_next = tcw_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            tcw_pkg::ST_READ:
            begin
                res_cell_next = rd_ok_reg ? rd_data : 8'd0;
                state_next    = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_SCROLL:
            begin
                // Reads run ahead of the writes they feed through the registered read port, a row apart.
                if (cnt_reg < tcw_pkg::cnt_t'(tcw_pkg::CELLS - tcw_pkg::COLUMNS))
                begin
                    rd_addr  = tcw_pkg::addr_t'(cnt_reg + tcw_pkg::cnt_t'(tcw_pkg::COLUMNS));
                    cnt_next = cnt_reg + tcw_pkg::cnt_t'(1);
                end
                else
                begin
                    state_next = tcw_pkg::ST_FILL;
                end
                if (cnt_reg != '0)
                begin
                    wr.en   = 1'b1;
                    wr.addr = tcw_pkg::addr_t'(cnt_reg - tcw_pkg::cnt_t'(1));
                    wr.data = rd_data;
                end
            end
            tcw_pkg::ST_FILL:
            begin
                wr.en   = 1'b1;
                wr.addr = tcw_pkg::addr_t'(cnt_reg);
                wr.data = tcw_pkg::SPACE_CODE;
                if (cnt_reg == tcw_pkg::cnt_t'(tcw_pkg::CELLS - 1))
                begin
                    state_next = tcw_pkg::ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + tcw_pkg::cnt_t'(1);
                end
            end
            tcw_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase

        out_valid_next  = load_out ? 1'b1 : (out_valid_reg && out_stall);
        cell_char_next  = load_out ? res_cell_reg : cell_char_reg;
        cursor_col_next = load_out ? 7'(col_reg) : cursor_col_reg;
        cursor_row_next = load_out ? 5'(row_reg) : cursor_row_reg;
        scrolled_next   = load_out ? res_scroll_reg : scrolled_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::ST_INIT;
            cnt_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_cell_reg   <= res_cell_next;
        res_scroll_reg <= res_scroll_next;
        rd_ok_reg      <= rd_ok_next;
        cell_char_reg  <= cell_char_next;
        cursor_col_reg <= cursor_col_next;
        cursor_row_reg <= cursor_row_next;
        scrolled_reg   <= scrolled_next;
    end

    assign in_stall   = (state_reg != tcw_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign cell_char  = cell_char_reg;
    assign cursor_col = cursor_col_reg;
    assign cursor_row = cursor_row_reg;
    assign scrolled   = scrolled_reg;

endmodule

// ===== hw/rtl/text_console_writer.sv =====
// Top level of the text console writer: sequencer plus cell store.
// Depends on tcw_pkg, tcw_ram and tcw_ctrl.
//
//   channel | direction | handshake           | fields
//   in      | input     | in_valid, in_stall  | op, char_code, cell_index
//   out     | output    | out_valid, out_stall| cell_char, cursor_col, cursor_row, scrolled
//
// A put, newline or unused op goes from ST_IDLE to ST_DONE; a read passes through ST_READ
// for the store's registered read port. A scroll copies each cell up a row in ST_SCROLL,
// then blanks the last row in ST_FILL; a clear writes spaces over all CELLS entries in ST_FILL.
// After reset a clearing pass writes spaces over all CELLS entries with in_stall high. The
// result waits in an output register; a stalled result holds the sequencer only once the
// next item has finished.
module text_console_writer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  char_code,
    input  logic [10:0] cell_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  cell_char,
    output logic [6:0]  cursor_col,
    output logic [4:0]  cursor_row,
    output logic        scrolled
);

    tcw_pkg::mem_wr_t wr;
    tcw_pkg::addr_t   rd_addr;
    logic [7:0]       rd_data;

    tcw_ram u_ram
    (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tcw_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .char_code  (char_code),
        .cell_index (cell_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_char  (cell_char),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .scrolled   (scrolled),
        .wr         (wr),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

`ifndef SYNTHESIS
    a_item_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Input accepted in two consecutive cycles.");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |->
            cursor_col == 7'd0 && cursor_row == 5'(tcw_pkg::ROWS - 1))
        else $error("Scroll result with cursor off the start of the last row.");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cursor_col < tcw_pkg::COLUMNS && cursor_row < tcw_pkg::ROWS)
        else $error("Cursor outside the screen.");

    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> wr.addr < tcw_pkg::CELLS)
        else $error("Cell store write beyond the screen.");
`endif

endmodule
